// File: rtl/core/ked_pkg.sv
// ----------------------------------------------------------------------------
// Key event detector package
// Shared types, codes and configuration defaults for the key event detector.
// ----------------------------------------------------------------------------
package ked_pkg;

    localparam int KEY_COUNT = 3;
    localparam int TIMER_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_READ_CLICK  = 3'd1,
        ACT_READ_LONG   = 3'd2,
        ACT_READ_REPEAT = 3'd3,
        ACT_CLEAR       = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLICK_EN     = 3'd0,
        REG_PRESSED_EN   = 3'd1,
        REG_REPEAT_EN    = 3'd2,
        REG_LONG_TICKS   = 3'd3,
        REG_REPEAT_START = 3'd4,
        REG_REPEAT_GAP   = 3'd5,
        REG_CEILING      = 3'd6
    } t_reg_index;

    localparam logic [TIMER_W-1:0] LONG_TICKS_RST   = 8'd50;
    localparam logic [TIMER_W-1:0] REPEAT_START_RST = 8'd50;
    localparam logic [TIMER_W-1:0] REPEAT_GAP_RST   = 8'd10;
    localparam logic [TIMER_W-1:0] CEILING_RST      = 8'd255;

    typedef struct packed {
        logic               pressed_enable;
        logic               repeat_enable;
        logic [TIMER_W-1:0] long_press_ticks;
        logic [TIMER_W-1:0] repeat_start_ticks;
        logic [TIMER_W-1:0] repeat_gap_ticks;
        logic [TIMER_W-1:0] timer_ceiling;
    } t_timer_cfg;

    typedef struct packed {
        logic tick;
        logic wipe;
        logic held;
        logic take_long;
        logic take_repeat;
    } t_key_ctrl;

    typedef struct packed {
        logic long_flag;
        logic repeat_flag;
        logic fired;
    } t_key_status;

endpackage

// File: rtl/core/ked_key_slice.sv
// ----------------------------------------------------------------------------
// Key event detector, per-key slice
// Hold and repeat timers with their long-press and repeat flags for one key.
// ----------------------------------------------------------------------------
module ked_key_slice (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ked_pkg::t_timer_cfg  i_cfg,
    input  ked_pkg::t_key_ctrl   i_ctrl,
    output ked_pkg::t_key_status o_status
);

    logic [ked_pkg::TIMER_W-1:0] r_hold_timer;
    logic [ked_pkg::TIMER_W-1:0] n_hold_timer;
    logic [ked_pkg::TIMER_W-1:0] r_repeat_timer;
    logic [ked_pkg::TIMER_W-1:0] n_repeat_timer;
    logic                        r_long_flag;
    logic                        n_long_flag;
    logic                        r_repeat_flag;
    logic                        n_repeat_flag;
    logic                        fired;

    always_comb begin
        n_hold_timer   = i_ctrl.wipe ? '0 : r_hold_timer;
        n_repeat_timer = i_ctrl.wipe ? '0 : r_repeat_timer;
        n_long_flag    = i_ctrl.wipe ? 1'b0 : r_long_flag;
        n_repeat_flag  = i_ctrl.wipe ? 1'b0 : r_repeat_flag;
        fired          = 1'b0;

        if (i_ctrl.tick) begin
            if (i_cfg.pressed_enable) begin
                if (i_ctrl.held && !n_long_flag) begin
                    if (n_hold_timer < i_cfg.timer_ceiling) begin
                        n_hold_timer = n_hold_timer + 1'b1;
                    end
                    if (n_hold_timer > i_cfg.long_press_ticks) begin
                        n_long_flag  = 1'b1;
                        n_hold_timer = '0;
                        fired        = 1'b1;
                    end
                end else begin
                    n_hold_timer = '0;
                end
            end
            if (i_cfg.repeat_enable) begin
                if (!i_ctrl.held) begin
                    n_repeat_timer = '0;
                    n_repeat_flag  = 1'b0;
                end else if (!n_repeat_flag) begin
                    if (n_repeat_timer < i_cfg.timer_ceiling) begin
                        n_repeat_timer = n_repeat_timer + 1'b1;
                    end
                    if ((n_repeat_timer > i_cfg.repeat_start_ticks) &&
                        ((n_repeat_timer - i_cfg.repeat_start_ticks) >
                         i_cfg.repeat_gap_ticks)) begin
                        n_repeat_flag  = 1'b1;
                        n_repeat_timer = i_cfg.repeat_start_ticks;
                        fired          = 1'b1;
                    end
                end
            end
        end

        if (i_ctrl.take_long) begin
            n_long_flag = 1'b0;
        end
        if (i_ctrl.take_repeat) begin
            n_repeat_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_timer   <= '0;
            r_repeat_timer <= '0;
            r_long_flag    <= 1'b0;
            r_repeat_flag  <= 1'b0;
        end else begin
            r_hold_timer   <= n_hold_timer;
            r_repeat_timer <= n_repeat_timer;
            r_long_flag    <= n_long_flag;
            r_repeat_flag  <= n_repeat_flag;
        end
    end

    assign o_status.long_flag   = r_long_flag;
    assign o_status.repeat_flag = r_repeat_flag;
    assign o_status.fired       = fired;

endmodule

// File: rtl/core/key_event_detector.sv
// ----------------------------------------------------------------------------
// Key event detector
// Click, long-press and auto-repeat detection for a small keypad, with
// clear-on-read event flags and a deferred clear request.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result
// register; the key state updates as the item leaves the input register.
// Throughput: one item per cycle unless the result side stalls; all key
// slices update in parallel.
// Reset: synchronous active-low; clears flags, timers and pending clear and
// loads the register defaults.
module key_event_detector (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [2:0]                     i_action,
    input  logic [ked_pkg::KEY_COUNT-1:0]  i_key_levels,
    input  logic [1:0]                     i_key_number,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_event_flag,
    output logic                           o_event_notify,
    output logic                           o_clear_waiting,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ked_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ked_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic                        r_click_enable;
    ked_pkg::t_timer_cfg         r_cfg;

    // Input register.
    logic                        r_in_valid;
    logic [2:0]                  r_action;
    logic [ked_pkg::KEY_COUNT-1:0] r_keys;
    logic [1:0]                  r_key;

    // Block state kept at this level.
    logic [ked_pkg::KEY_COUNT-1:0] r_previous_keys;
    logic [ked_pkg::KEY_COUNT-1:0] n_previous_keys;
    logic [ked_pkg::KEY_COUNT-1:0] r_click_flags;
    logic [ked_pkg::KEY_COUNT-1:0] n_click_flags;
    logic                        r_clear_pending;
    logic                        n_clear_pending;

    // Result register.
    logic                        r_out_valid;
    logic                        r_event_flag;
    logic                        r_event_notify;
    logic                        r_clear_waiting;

    logic                        go;
    logic                        result_free;
    logic                        is_tick;
    logic                        is_clear;
    logic                        key_valid;
    logic                        keys_idle;
    logic                        wipe;
    logic [ked_pkg::KEY_COUNT-1:0] key_sel;
    logic [ked_pkg::KEY_COUNT-1:0] long_flags;
    logic [ked_pkg::KEY_COUNT-1:0] repeat_flags;
    logic [ked_pkg::KEY_COUNT-1:0] key_fired;
    ked_pkg::t_key_ctrl          key_ctrl   [ked_pkg::KEY_COUNT];
    ked_pkg::t_key_status        key_status [ked_pkg::KEY_COUNT];
    logic                        n_event_flag;
    logic                        n_event_notify;

    assign result_free = !r_out_valid || i_out_ready;
    assign go          = r_in_valid && result_free;
    assign o_in_ready  = !r_in_valid || result_free;
    assign o_cfg_ready = 1'b1;

    assign is_tick   = go && (r_action == ked_pkg::ACT_TICK);
    assign is_clear  = go && (r_action == ked_pkg::ACT_CLEAR);
    assign keys_idle = (r_keys == '0);
    assign key_valid = (32'(r_key) < ked_pkg::KEY_COUNT);
    assign wipe      = keys_idle && ((is_tick && r_clear_pending) || is_clear);

    always_comb begin
        for (int k = 0; k < ked_pkg::KEY_COUNT; k++) begin
            key_sel[k] = key_valid && (32'(r_key) == k);
        end
    end

    for (genvar g = 0; g < ked_pkg::KEY_COUNT; g++) begin : g_key
        assign key_ctrl[g].tick        = is_tick;
        assign key_ctrl[g].wipe        = wipe;
        assign key_ctrl[g].held        = r_keys[g];
        assign key_ctrl[g].take_long   =
            go && (r_action == ked_pkg::ACT_READ_LONG) && key_sel[g];
        assign key_ctrl[g].take_repeat =
            go && (r_action == ked_pkg::ACT_READ_REPEAT) && key_sel[g];

        ked_key_slice u_slice (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (r_cfg),
            .i_ctrl   (key_ctrl[g]),
            .o_status (key_status[g])
        );

        assign long_flags[g]   = key_status[g].long_flag;
        assign repeat_flags[g] = key_status[g].repeat_flag;
        assign key_fired[g]    = key_status[g].fired;
    end

    always_comb begin
        n_previous_keys = wipe ? '0 : r_previous_keys;
        n_click_flags   = wipe ? '0 : r_click_flags;
        n_clear_pending = r_clear_pending;
        n_event_flag    = 1'b0;
        n_event_notify  = 1'b0;

        case (r_action)
            ked_pkg::ACT_TICK: begin
                if (wipe) begin
                    n_clear_pending = 1'b0;
                end
                if (r_click_enable) begin
                    n_click_flags = (n_previous_keys ^ r_keys) & r_keys;
                end
                n_event_notify  = (r_click_enable && (n_click_flags != '0)) ||
                                  (key_fired != '0);
                n_previous_keys = r_keys;
            end
            ked_pkg::ACT_READ_CLICK: begin
                n_event_flag  = |(r_click_flags & key_sel);
                n_click_flags = r_click_flags & ~key_sel;
            end
            ked_pkg::ACT_READ_LONG: begin
                n_event_flag = |(long_flags & key_sel);
            end
            ked_pkg::ACT_READ_REPEAT: begin
                n_event_flag = |(repeat_flags & key_sel);
            end
            ked_pkg::ACT_CLEAR: begin
                n_clear_pending = !keys_idle;
            end
            default: begin
                n_event_flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_enable           <= 1'b1;
            r_cfg.pressed_enable     <= 1'b1;
            r_cfg.repeat_enable      <= 1'b1;
            r_cfg.long_press_ticks   <= ked_pkg::LONG_TICKS_RST;
            r_cfg.repeat_start_ticks <= ked_pkg::REPEAT_START_RST;
            r_cfg.repeat_gap_ticks   <= ked_pkg::REPEAT_GAP_RST;
            r_cfg.timer_ceiling      <= ked_pkg::CEILING_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ked_pkg::REG_CLICK_EN:     r_click_enable           <= i_cfg_data[0];
                ked_pkg::REG_PRESSED_EN:   r_cfg.pressed_enable     <= i_cfg_data[0];
                ked_pkg::REG_REPEAT_EN:    r_cfg.repeat_enable      <= i_cfg_data[0];
                ked_pkg::REG_LONG_TICKS:   r_cfg.long_press_ticks   <= i_cfg_data;
                ked_pkg::REG_REPEAT_START: r_cfg.repeat_start_ticks <= i_cfg_data;
                ked_pkg::REG_REPEAT_GAP:   r_cfg.repeat_gap_ticks   <= i_cfg_data;
                ked_pkg::REG_CEILING:      r_cfg.timer_ceiling      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_keys   <= i_key_levels;
            r_key    <= i_key_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_previous_keys <= '0;
            r_click_flags   <= '0;
            r_clear_pending <= 1'b0;
        end else if (go) begin
            r_previous_keys <= n_previous_keys;
            r_click_flags   <= n_click_flags;
            r_clear_pending <= n_clear_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_event_flag    <= n_event_flag;
            r_event_notify  <= n_event_notify;
            r_clear_waiting <= n_clear_pending;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_flag    = r_event_flag;
    assign o_event_notify  = r_event_notify;
    assign o_clear_waiting = r_clear_waiting;

endmodule

// File: sim/tb_key_event_detector.sv
// ----------------------------------------------------------------------------
// Key event detector testbench
// Drives ticks, flag reads and clear requests through the item channel and
// checks each result against an in-bench model of the keypad state. It covers
// the register extremes, timer saturation and random hold sequences, and it
// idles both sides of the handshake at random.
// ----------------------------------------------------------------------------
module tb_key_event_detector;

    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
    localparam logic [1:0] KEY_BEYOND    = 2'd3;
    localparam int         MAX_PRINTS    = 50;

    typedef struct packed {
        logic flag;
        logic notify;
        logic waiting;
    } t_expect;

    logic                          i_clk;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic [2:0]                    i_action       = ked_pkg::ACT_TICK;
    logic [ked_pkg::KEY_COUNT-1:0] i_key_levels   = '0;
    logic [1:0]                    i_key_number   = '0;
    logic                          i_out_ready    = 1'b0;
    logic                          i_cfg_valid    = 1'b0;
    logic [ked_pkg::CFG_IDX_W-1:0] i_cfg_index    = ked_pkg::REG_CLICK_EN;
    logic [ked_pkg::CFG_DAT_W-1:0] i_cfg_data     = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic                          o_event_flag;
    logic                          o_event_notify;
    logic                          o_clear_waiting;
    logic                          o_cfg_ready;

    key_event_detector u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_key_levels    (i_key_levels),
        .i_key_number    (i_key_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_flag    (o_event_flag),
        .o_event_notify  (o_event_notify),
        .o_clear_waiting (o_clear_waiting),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Model of the keypad state and registers.
    logic                        en_click;
    logic                        en_long;
    logic                        en_repeat;
    logic [ked_pkg::TIMER_W-1:0] long_limit;
    logic [ked_pkg::TIMER_W-1:0] repeat_start;
    logic [ked_pkg::TIMER_W-1:0] repeat_gap;
    logic [ked_pkg::TIMER_W-1:0] count_ceiling;

    logic [ked_pkg::KEY_COUNT-1:0] key_prev;
    logic [ked_pkg::KEY_COUNT-1:0] click_pending;
    logic [ked_pkg::KEY_COUNT-1:0] long_pending;
    logic [ked_pkg::KEY_COUNT-1:0] repeat_pending;
    logic                          clear_armed;
    logic [ked_pkg::TIMER_W-1:0]   hold_count   [ked_pkg::KEY_COUNT];
    logic [ked_pkg::TIMER_W-1:0]   repeat_count [ked_pkg::KEY_COUNT];

    t_expect expected_results [$];
    int      err_count   = 0;
    bit      src_stalls  = 1'b0;
    bit      sink_stalls = 1'b0;
    int      ready_hold  = 0;
    int      sink_roll;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("tb_key_event_detector: done, errors");
        $finish;
    end

    function automatic void wipe_keypad();
        key_prev       = '0;
        click_pending  = '0;
        long_pending   = '0;
        repeat_pending = '0;
        for (int k = 0; k < ked_pkg::KEY_COUNT; k++) begin
            hold_count[k]   = '0;
            repeat_count[k] = '0;
        end
    endfunction

    function automatic t_expect predict_item(logic [2:0] act,
                                             logic [ked_pkg::KEY_COUNT-1:0] keys,
                                             logic [1:0] num);
        t_expect e;
        logic    fired;
        logic    in_range;
        e        = '0;
        fired    = 1'b0;
        in_range = (num < ked_pkg::KEY_COUNT);
        case (act)
            ked_pkg::ACT_TICK: begin
                if (clear_armed && keys == '0) begin
                    clear_armed = 1'b0;
                    wipe_keypad();
                end
                if (en_click) begin
                    click_pending = ~key_prev & keys;
                    if (click_pending != '0) fired = 1'b1;
                end
                for (int k = 0; k < ked_pkg::KEY_COUNT; k++) begin
                    if (en_long) begin
                        if (keys[k] && !long_pending[k]) begin
                            if (hold_count[k] < count_ceiling) hold_count[k]++;
                            if (hold_count[k] > long_limit) begin
                                long_pending[k] = 1'b1;
                                hold_count[k]   = '0;
                                fired           = 1'b1;
                            end
                        end else begin
                            hold_count[k] = '0;
                        end
                    end
                    if (en_repeat) begin
                        if (!keys[k]) begin
                            repeat_count[k]   = '0;
                            repeat_pending[k] = 1'b0;
                        end else if (!repeat_pending[k]) begin
                            if (repeat_count[k] < count_ceiling) repeat_count[k]++;
                            if (repeat_count[k] > repeat_start &&
                                repeat_count[k] - repeat_start > repeat_gap) begin
                                repeat_pending[k] = 1'b1;
                                repeat_count[k]   = repeat_start;
                                fired             = 1'b1;
                            end
                        end
                    end
                end
                key_prev = keys;
                e.notify = fired;
            end
            ked_pkg::ACT_READ_CLICK: begin
                if (in_range) begin
                    e.flag             = click_pending[num];
                    click_pending[num] = 1'b0;
                end
            end
            ked_pkg::ACT_READ_LONG: begin
                if (in_range) begin
                    e.flag            = long_pending[num];
                    long_pending[num] = 1'b0;
                end
            end
            ked_pkg::ACT_READ_REPEAT: begin
                if (in_range) begin
                    e.flag              = repeat_pending[num];
                    repeat_pending[num] = 1'b0;
                end
            end
            ked_pkg::ACT_CLEAR: begin
                if (keys != '0) begin
                    clear_armed = 1'b1;
                end else begin
                    clear_armed = 1'b0;
                    wipe_keypad();
                end
            end
            default: begin
            end
        endcase
        e.waiting = clear_armed;
        return e;
    endfunction

    function automatic void load_register(ked_pkg::t_reg_index idx,
                                          logic [ked_pkg::CFG_DAT_W-1:0] val);
        case (idx)
            ked_pkg::REG_CLICK_EN:     en_click      = val[0];
            ked_pkg::REG_PRESSED_EN:   en_long       = val[0];
            ked_pkg::REG_REPEAT_EN:    en_repeat     = val[0];
            ked_pkg::REG_LONG_TICKS:   long_limit    = val;
            ked_pkg::REG_REPEAT_START: repeat_start  = val;
            ked_pkg::REG_REPEAT_GAP:   repeat_gap    = val;
            ked_pkg::REG_CEILING:      count_ceiling = val;
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string what);
        if (err_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_expect want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item outstanding");
            end else begin
                want = expected_results.pop_front();
                if (o_event_flag !== want.flag)
                    report_mismatch($sformatf("event_flag %b, want %b", o_event_flag,
                                              want.flag));
                if (o_event_notify !== want.notify)
                    report_mismatch($sformatf("event_notify %b, want %b", o_event_notify,
                                              want.notify));
                if (o_clear_waiting !== want.waiting)
                    report_mismatch($sformatf("clear_waiting %b, want %b", o_clear_waiting,
                                              want.waiting));
            end
        end
    end

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (!sink_stalls || sink_roll < 70) begin
                i_out_ready <= 1'b1;
                ready_hold  <= $urandom_range(0, 8);
            end else if (sink_roll < 96) begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_hold  <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_stalls || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(logic [2:0] act, logic [ked_pkg::KEY_COUNT-1:0] keys,
                             logic [1:0] num);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_key_levels <= keys;
        i_key_number <= num;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(predict_item(act, keys, num));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(ked_pkg::t_reg_index idx,
                             logic [ked_pkg::CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        load_register(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(bit ce, bit pe, bit re, logic [7:0] lp, logic [7:0] rs,
                              logic [7:0] rg, logic [7:0] ceil);
        drain_results();
        repeat (4) @(posedge i_clk);
        // Upper data bits of the enable registers are don't-care; toggle them anyway.
        write_reg(ked_pkg::REG_CLICK_EN,     {7'($urandom), ce});
        write_reg(ked_pkg::REG_PRESSED_EN,   {7'($urandom), pe});
        write_reg(ked_pkg::REG_REPEAT_EN,    {7'($urandom), re});
        write_reg(ked_pkg::REG_LONG_TICKS,   lp);
        write_reg(ked_pkg::REG_REPEAT_START, rs);
        write_reg(ked_pkg::REG_REPEAT_GAP,   rg);
        write_reg(ked_pkg::REG_CEILING,      ceil);
    endtask

    task automatic run_keypad_session(int n_items);
        int                            sent;
        int                            hold_len;
        int                            r;
        logic [ked_pkg::KEY_COUNT-1:0] held_keys;
        sent = 0;
        while (sent < n_items) begin
            r         = $urandom_range(0, 99);
            held_keys = (ked_pkg::KEY_COUNT)'($urandom);
            if (r < 85) hold_len = $urandom_range(1, 12);
            else if (r < 97) hold_len = $urandom_range(13, 70);
            else hold_len = $urandom_range(200, 300);
            for (int s = 0; s < hold_len && sent < n_items; s++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    send_item(ked_pkg::ACT_TICK, held_keys, 2'($urandom));
                end else if (r < 63) begin
                    send_item(ked_pkg::ACT_TICK, (ked_pkg::KEY_COUNT)'($urandom),
                              2'($urandom));
                end else if (r < 90) begin
                    send_item(3'($urandom_range(ked_pkg::ACT_READ_CLICK,
                                                ked_pkg::ACT_READ_REPEAT)),
                              (ked_pkg::KEY_COUNT)'($urandom),
                              ($urandom_range(0, 15) == 0) ? KEY_BEYOND
                                                           : 2'($urandom_range(0, 2)));
                end else if (r < 94) begin
                    send_item(ked_pkg::ACT_CLEAR, $urandom_range(0, 1) ? held_keys : '0,
                              2'($urandom));
                end else if (r < 96) begin
                    send_item(3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
                              (ked_pkg::KEY_COUNT)'($urandom), 2'($urandom));
                end else begin
                    send_item(ked_pkg::ACT_TICK, '0, 2'($urandom));
                end
                sent++;
                if ($urandom_range(0, 199) == 0) drain_results();
            end
        end
    endtask

    task automatic test_reset_state();
        src_stalls  = 1'b0;
        sink_stalls = 1'b0;
        send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        send_item(ked_pkg::ACT_READ_CLICK, 3'b000, 2'd1);
        send_item(ked_pkg::ACT_TICK, 3'b000, 2'd0);
    endtask

    task automatic test_directed_basics();
        set_config(1'b1, 1'b1, 1'b1, 8'd2, 8'd1, 8'd0, 8'd255);
        send_item(ked_pkg::ACT_TICK, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        send_item(ked_pkg::ACT_READ_CLICK, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_READ_CLICK, 3'b000, 2'd1);
        send_item(ked_pkg::ACT_READ_CLICK, 3'b111, KEY_BEYOND);
        send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        send_item(ked_pkg::ACT_READ_LONG, 3'b000, 2'd2);
        send_item(ked_pkg::ACT_READ_REPEAT, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_READ_REPEAT, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_TICK, 3'b011, 2'd0);
        send_item(ked_pkg::ACT_READ_REPEAT, 3'b000, 2'd2);
        send_item(ACT_UNUSED_LO, 3'b111, KEY_BEYOND);
        send_item(ACT_UNUSED_HI, 3'b111, 2'd2);
        // A clear with a key held stays armed until a tick sees no key held.
        send_item(ked_pkg::ACT_CLEAR, 3'b001, 2'd0);
        send_item(ked_pkg::ACT_TICK, 3'b001, 2'd0);
        send_item(ked_pkg::ACT_READ_LONG, 3'b000, 2'd1);
        send_item(ked_pkg::ACT_TICK, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_CLEAR, 3'b000, 2'd0);
        send_item(ked_pkg::ACT_TICK, 3'b100, 2'd0);
        send_item(ked_pkg::ACT_CLEAR, 3'b100, 2'd0);
        send_item(ked_pkg::ACT_CLEAR, 3'b000, 2'd0);
    endtask

    task automatic test_timer_saturation();
        set_config(1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd0, 8'd255);
        src_stalls = 1'b1;
        for (int s = 0; s < 260; s++) begin
            if (s % 50 == 49) send_item(ked_pkg::ACT_READ_LONG, 3'b111, 2'(s % 3));
            else send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        end
        drain_results();
        repeat (4) @(posedge i_clk);
        write_reg(ked_pkg::REG_LONG_TICKS, 8'd254);
        send_item(ked_pkg::ACT_TICK, 3'b111, 2'd0);
        send_item(ked_pkg::ACT_READ_LONG, 3'b000, 2'd1);
        send_item(ked_pkg::ACT_TICK, 3'b000, 2'd0);
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: set_config(1'b1, 1'b1, 1'b1, 8'd50, 8'd50, 8'd10, 8'd255);
                1: set_config(1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd255);
                2: set_config(1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
                3: set_config(1'b1, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
                4: set_config(1'b0, 1'b0, 1'b0, 8'd3, 8'd2, 8'd1, 8'd20);
                5: set_config(1'b1, 1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd20);
                default: set_config(1'b1, 1'b0, 1'b1, 8'd3, 8'd2, 8'd1, 8'd5);
            endcase
            src_stalls  = (p % 3 != 0);
            sink_stalls = (p % 2 == 0);
            run_keypad_session(150);
        end
    endtask

    task automatic test_random_settings();
        repeat (5) begin
            set_config($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                       $urandom_range(0, 3) != 0,
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                       $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom),
                       ($urandom_range(0, 9) < 7) ? 8'd255 : 8'($urandom));
            src_stalls  = $urandom_range(0, 3) != 0;
            sink_stalls = $urandom_range(0, 3) != 0;
            run_keypad_session(130);
        end
    endtask

    initial begin
        en_click      = 1'b1;
        en_long       = 1'b1;
        en_repeat     = 1'b1;
        long_limit    = ked_pkg::LONG_TICKS_RST;
        repeat_start  = ked_pkg::REPEAT_START_RST;
        repeat_gap    = ked_pkg::REPEAT_GAP_RST;
        count_ceiling = ked_pkg::CEILING_RST;
        clear_armed   = 1'b0;
        wipe_keypad();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_basics();
        test_timer_saturation();
        test_config_sweep();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_key_event_detector: done, clean");
        end else begin
            $display("tb_key_event_detector: done, errors");
        end
        $finish;
    end

endmodule
